// ===== design/wpm_pkg.sv =====
// Package for the wildcard pattern matcher: sizes, codes and shared types.
package wpm_pkg;

  localparam int MaxPattern = 16;
  localparam int ByteW      = 8;
  localparam int LenW       = $clog2(MaxPattern + 1);
  localparam int WordW      = 64;
  localparam int PatW       = MaxPattern * ByteW;
  localparam int CfgIdxW    = 2;

  localparam logic [ByteW-1:0] StarCode  = 8'h2A;
  localparam logic [ByteW-1:0] QmarkCode = 8'h3F;

  typedef enum logic [CfgIdxW-1:0] {
    CfgLen  = 2'd0,
    CfgLow  = 2'd1,
    CfgHigh = 2'd2
  } cfg_idx_e;

  // Per-beat controls broadcast to every cell.
  typedef struct packed {
    logic adv;    // accepted beat that advances the row
    logic first;  // restart row before this byte
    logic empty;  // load the initial row only
  } ctl_t;

  // What one cell hands to its right neighbor (values for its prefix).
  typedef struct packed {
    logic init;   // initial-row bit
    logic cur;    // row bit the step starts from
    logic nxt;    // row bit after the step
  } link_t;

  typedef struct packed {
    logic full_match;
    logic end_of_string;
  } result_t;

endpackage

// ===== design/wpm_cell.sv =====
// One pattern position: holds its match bit and extends the row recurrence.
module wpm_cell import wpm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctl_t             ctl_i,
  input  logic [ByteW-1:0] text_byte_i,
  input  logic [ByteW-1:0] pat_byte_i,
  input  logic             active_i,
  input  link_t            left_i,
  output link_t            right_o
);

  logic row_q, row_d;
  logic is_star, hit;
  logic init_b, cur_b, nxt_b;

  always_comb begin
    is_star = (pat_byte_i == StarCode);
    hit     = (pat_byte_i == QmarkCode) || (pat_byte_i == text_byte_i);
    init_b  = active_i && left_i.init && is_star;
    cur_b   = ctl_i.first ? init_b : row_q;
    if (!active_i) begin
      nxt_b = 1'b0;
    end else if (is_star) begin
      nxt_b = left_i.nxt || cur_b;     // star chain ripples left to right
    end else begin
      nxt_b = hit && left_i.cur;
    end

    row_d = row_q;
    if (ctl_i.empty) begin
      row_d = init_b;
    end else if (ctl_i.adv) begin
      row_d = nxt_b;
    end

    right_o.init = init_b;
    right_o.cur  = cur_b;
    right_o.nxt  = nxt_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= 1'b0;
    end else begin
      row_q <= row_d;
    end
  end

endmodule

// ===== design/wildcard_pattern_match.sv =====
// Top level of the streaming wildcard pattern matcher.
//
// Matches a text stream against a wildcard pattern of up to 16 bytes held in
// configuration registers ('?' = any one byte, '*' = any run, empty included).
// Each accepted input beat carries one text byte and yields exactly one result
// beat telling whether the text seen so far matches the whole pattern. A beat
// with first_byte restarts the text; a beat with empty_string reports the
// empty text (match only if the pattern is all stars) and ignores the byte.
// Throughput is one byte per clock, back to back, while in_stall_o is low;
// each result is written into the output queue as its byte is accepted. The
// match state lives in a row of 16 cells, one per pattern position, and the
// star chain ripples through all cells within the cycle, which sets the clock
// limit. Results pass through a two-entry output queue, so input keeps
// flowing while one result waits; in_stall_o rises only when both entries are held. Configuration is written
// through a plain write port (index 0 length, 1 bytes 0-7, 2 bytes 8-15) while idle, which the user must keep to;
// the block does not enforce it. A new pattern applies from the next byte. No clearing pass after reset.
module wildcard_pattern_match import wpm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [WordW-1:0]   cfg_data_i,
  // input beats
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   text_byte_i,
  input  logic               first_byte_i,
  input  logic               last_byte_i,
  input  logic               empty_string_i,
  // result beats
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               full_match_o,
  output logic               end_of_string_o
);

  // Configuration registers
  logic [LenW-1:0]  pat_len_q;
  logic [WordW-1:0] pat_low_q, pat_high_q;
  logic [PatW-1:0]  pattern;
  logic [LenW-1:0]  eff_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_len_q  <= '0;
      pat_low_q  <= '0;
      pat_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgLen:  pat_len_q  <= cfg_data_i[LenW-1:0];
        CfgLow:  pat_low_q  <= cfg_data_i;
        CfgHigh: pat_high_q <= cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  assign pattern = {pat_high_q, pat_low_q};
  // Lengths past the cell count saturate.
  assign eff_len = (pat_len_q > LenW'(MaxPattern)) ? LenW'(MaxPattern) : pat_len_q;

  // Beat handshakes
  logic push, pop;
  assign push = in_valid_i && !in_stall_o;
  assign pop  = out_valid_o && !out_stall_i;

  ctl_t ctl;
  assign ctl.adv   = push && !empty_string_i;
  assign ctl.first = first_byte_i;
  assign ctl.empty = push && empty_string_i;

  // Prefix 0: matches at string start, never after a consumed byte.
  logic row0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q <= 1'b0;
    end else if (ctl.empty) begin
      row0_q <= 1'b1;
    end else if (ctl.adv) begin
      row0_q <= 1'b0;
    end
  end

  // Cell chain
  link_t links [MaxPattern+1];
  logic [MaxPattern:0] init_v, nxt_v;

  assign links[0].init = 1'b1;
  assign links[0].cur  = first_byte_i ? 1'b1 : row0_q;
  assign links[0].nxt  = 1'b0;
  assign init_v[0]     = 1'b1;
  assign nxt_v[0]      = 1'b0;

  for (genvar g = 0; g < MaxPattern; g++) begin : g_cell
    wpm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .text_byte_i (text_byte_i),
      .pat_byte_i  (pattern[g*ByteW +: ByteW]),
      .active_i    (LenW'(g) < eff_len),
      .left_i      (links[g]),
      .right_o     (links[g+1])
    );
    assign init_v[g+1] = links[g+1].init;
    assign nxt_v[g+1]  = links[g+1].nxt;
  end

  result_t res_new;
  assign res_new.full_match    = empty_string_i ? init_v[eff_len] : nxt_v[eff_len];
  assign res_new.end_of_string = empty_string_i || last_byte_i;

  // Two-entry result queue; slot 0 is the head.
  result_t    slot_q [2];
  result_t    slot_d [2];
  logic [1:0] count_q;
  logic       wr_idx;

  assign wr_idx = (count_q == 2'd2) ? 1'b1 : (count_q[0] && !pop);

  // Pop shifts slot 1 forward; a push in the same cycle lands behind any entry still held.
  always_comb begin
    slot_d[0] = slot_q[0];
    slot_d[1] = slot_q[1];
    if (pop) begin
      slot_d[0] = slot_q[1];
    end
    if (push) begin
      slot_d[wr_idx] = res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q[0] <= '0;
      slot_q[1] <= '0;
    end else begin
      slot_q[0] <= slot_d[0];
      slot_q[1] <= slot_d[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assign in_stall_o      = (count_q == 2'd2);
  assign out_valid_o     = (count_q != 2'd0);
  assign full_match_o    = slot_q[0].full_match;
  assign end_of_string_o = slot_q[0].end_of_string;

endmodule

// ===== design/wpm_checker.sv =====
// Port-level checks for the wildcard pattern matcher, bound to the top level.
module wpm_checker import wpm_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             empty_string_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             full_match_o,
  input logic             end_of_string_o
);

  logic in_beat;
  assign in_beat = in_valid_i && !in_stall_o;

  // Input backpressure only while results are queued.
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result queued");

  // No result appears without an input beat.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !in_beat) |=> !out_valid_o)
    else $error("result without input beat");

  // Empty-string beat into an empty queue shows up next cycle as end of string.
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && empty_string_i && !out_valid_o) |=> (out_valid_o && end_of_string_o))
    else $error("empty-string result missing or not marked end");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(full_match_o) && $stable(end_of_string_o)))
    else $error("stalled result changed");

endmodule

bind wildcard_pattern_match wpm_checker u_wpm_checker (.*);

// ===== sim/tb_wildcard_pattern_match.sv =====
// Testbench for the streaming wildcard pattern matcher: directed and random beats, scoreboard.
`timescale 1ns / 1ps

module tb_wildcard_pattern_match;
  import wpm_pkg::*;

  // Quiet-cycle limit. The longest correct stretch without any beat is the
  // forced receiver hold-off (HoldCycles) or a run of random stalls at 79%,
  // both far below this.
  localparam int QuietLimit = 2000;
  localparam int HoldCycles = 40;
  localparam int RandPhases = 12;
  localparam int PhaseBeats = 50;

  // Text letters that random patterns also use, so strings hit literals.
  localparam logic [ByteW-1:0] LetterA = 8'h61;
  localparam logic [ByteW-1:0] LetterB = 8'h62;

  typedef struct packed {
    logic [ByteW-1:0] txt;
    logic             is_first;
    logic             is_last;
    logic             is_empty;
  } text_beat_t;

  // DUT ports
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [WordW-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [ByteW-1:0]   text_byte_i = '0;
  logic               first_byte_i = 1'b0;
  logic               last_byte_i = 1'b0;
  logic               empty_string_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               full_match_o;
  logic               end_of_string_o;

  // Beats waiting to be sent, match verdicts waiting to come back.
  text_beat_t text_beats_q[$];
  result_t    verdicts_q[$];
  logic [ByteW-1:0] scratch_text[$];

  // Shadow of the pattern registers and the prefix-match row.
  logic [LenW-1:0]       shadow_len = '0;
  logic [WordW-1:0]      shadow_low = '0;
  logic [WordW-1:0]      shadow_high = '0;
  logic [MaxPattern:0]   prefix_row = '0;

  // Idling controls: the percentages and hold_on change at the falling edge, hold_cnt at the rising edge.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_on = 1'b0;
  int hold_cnt = 0;

  int mismatches = 0;
  int beats_queued = 0;
  int quiet_cycles = 0;

  wildcard_pattern_match dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Matcher prediction
  // ---------------------------------------------------------------------------

  // Pattern length in use: the register value saturated at the row size.
  function automatic int active_length();
    return (shadow_len > MaxPattern) ? MaxPattern : int'(shadow_len);
  endfunction

  function automatic logic [ByteW-1:0] pattern_char(int k);
    if (k < 8) return shadow_low[8*k +: 8];
    if (k < 16) return shadow_high[8*(k-8) +: 8];
    return '0;
  endfunction

  // Row for the empty text: prefix 0, then every prefix that is all stars.
  function automatic logic [MaxPattern:0] seed_prefix_row(int m);
    logic [MaxPattern:0] row;
    row = '0;
    row[0] = 1'b1;
    for (int j = 1; j <= m; j++) row[j] = row[j-1] && (pattern_char(j-1) == StarCode);
    return row;
  endfunction

  // One text byte: a star extends either the shorter prefix of the new row
  // (empty run) or the same prefix of the old row (one more byte).
  function automatic logic [MaxPattern:0] step_prefix_row(logic [MaxPattern:0] row, int m,
                                                          logic [ByteW-1:0] c);
    logic [MaxPattern:0] nxt;
    logic [ByteW-1:0]    p;
    nxt = '0;
    for (int j = 1; j <= m; j++) begin
      p = pattern_char(j-1);
      if (p == StarCode) begin
        nxt[j] = nxt[j-1] | row[j];
      end else if (p == QmarkCode || p == c) begin
        nxt[j] = row[j-1];
      end
    end
    return nxt;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one beat from the queue whenever the previous one has gone
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : send_proc
    text_beat_t b;
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (text_beats_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        b = text_beats_q.pop_front();
        in_valid_i     <= 1'b1;
        text_byte_i    <= b.txt;
        first_byte_i   <= b.is_first;
        last_byte_i    <= b.is_last;
        empty_string_i <= b.is_empty;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or one long counted hold-off while hold_on is up.
  always @(posedge clk_i) begin
    if (hold_on && hold_cnt < HoldCycles) begin
      out_stall_i <= 1'b1;
      hold_cnt    <= hold_cnt + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      if (!hold_on) hold_cnt <= 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: shadow register writes, predict on input beats, check output beats
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_proc
    int      m;
    result_t want;
    result_t got;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgLen:  shadow_len  = cfg_data_i[LenW-1:0];
          CfgLow:  shadow_low  = cfg_data_i;
          CfgHigh: shadow_high = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        m = active_length();
        if (empty_string_i || first_byte_i) prefix_row = seed_prefix_row(m);
        if (!empty_string_i) prefix_row = step_prefix_row(prefix_row, m, text_byte_i);
        want.full_match    = prefix_row[m];
        want.end_of_string = empty_string_i | last_byte_i;
        verdicts_q.push_back(want);
      end
      if (out_valid_o && !out_stall_i) begin
        got.full_match    = full_match_o;
        got.end_of_string = end_of_string_o;
        if (verdicts_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing expected (full_match %0b eos %0b)",
                     $realtime, got.full_match, got.end_of_string);
        end else begin
          want = verdicts_q.pop_front();
          if (want.full_match !== got.full_match || want.end_of_string !== got.end_of_string)
          begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch full_match exp %0b got %0b, eos exp %0b got %0b",
                       $realtime, want.full_match, got.full_match,
                       want.end_of_string, got.end_of_string);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either side and no register write.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers (called at the falling edge)
  // ---------------------------------------------------------------------------
  task automatic queue_beat(logic [ByteW-1:0] txt, logic f, logic l, logic e);
    text_beat_t b;
    b.txt      = txt;
    b.is_first = f;
    b.is_last  = l;
    b.is_empty = e;
    text_beats_q.push_back(b);
    beats_queued++;
  endtask

  // Send scratch_text as one string; no bytes means an empty-string beat
  // with junk in the ignored fields.
  task automatic flush_scratch();
    if (scratch_text.size() == 0) begin
      queue_beat(ByteW'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                 1'b1);
    end else begin
      for (int i = 0; i < scratch_text.size(); i++)
        queue_beat(scratch_text[i], i == 0, i == scratch_text.size() - 1, 1'b0);
    end
    scratch_text.delete();
  endtask

  function automatic logic [ByteW-1:0] pick_text_char();
    case ($urandom_range(9))
      0, 1:    return LetterA;
      2:       return LetterB;
      3:       return StarCode;
      4:       return QmarkCode;
      default: return ByteW'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [ByteW-1:0] pick_pattern_char();
    case ($urandom_range(9))
      0, 1, 2: return StarCode;
      3, 4:    return QmarkCode;
      5, 6:    return LetterA;
      7:       return LetterB;
      default: return ByteW'($urandom_range(255));
    endcase
  endfunction

  // Mostly strings built to fit the current pattern (some garbled), then
  // free strings, empty strings and loose beats with random marks.
  task automatic queue_random_string();
    int kind;
    int m;
    int pos;
    logic [ByteW-1:0] p;
    kind = $urandom_range(99);
    m = active_length();
    if (kind < 60) begin
      for (int k = 0; k < m; k++) begin
        p = pattern_char(k);
        if (p == StarCode) begin
          repeat ($urandom_range(3)) scratch_text.push_back(pick_text_char());
        end else if (p == QmarkCode) begin
          scratch_text.push_back(ByteW'($urandom_range(255)));
        end else begin
          scratch_text.push_back(p);
        end
      end
      if (kind < 15 && scratch_text.size() != 0) begin
        pos = $urandom_range(scratch_text.size() - 1);
        case ($urandom_range(2))
          0:       scratch_text[pos] = ByteW'($urandom_range(255));
          1:       scratch_text.delete(pos);
          default: scratch_text.insert(pos, pick_text_char());
        endcase
      end
      flush_scratch();
    end else if (kind < 78) begin
      repeat ($urandom_range(1, 6)) scratch_text.push_back(pick_text_char());
      flush_scratch();
    end else if (kind < 86) begin
      flush_scratch();
    end else begin
      queue_beat(pick_text_char(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                 $urandom_range(3) == 0);
    end
  endtask

  // Register writes at rising edges; returns at a falling edge.
  task automatic write_pattern(logic [WordW-1:0] len_word, logic [WordW-1:0] low_word,
                               logic [WordW-1:0] high_word);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgLen;
    cfg_data_i  <= len_word;
    @(posedge clk_i);
    cfg_index_i <= CfgLow;
    cfg_data_i  <= low_word;
    @(posedge clk_i);
    cfg_index_i <= CfgHigh;
    cfg_data_i  <= high_word;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  // Block is idle once every queued beat went in and every verdict came out.
  task automatic wait_drained();
    @(negedge clk_i);
    while (text_beats_q.size() != 0 || in_valid_i || verdicts_q.size() != 0)
      @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    logic [WordW-1:0] low_word;
    logic [WordW-1:0] high_word;
    logic [WordW-1:0] len_word;
    int half_mark;
    int end_mark;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // No start mark yet: row stays clear, so no match; then the empty string
    // against the empty reset pattern does match. Extreme text bytes.
    queue_beat(8'h00, 1'b0, 1'b0, 1'b0);
    queue_beat(8'hFF, 1'b0, 1'b1, 1'b0);
    queue_beat(8'hFF, 1'b1, 1'b0, 1'b1);
    wait_drained();

    // Pattern "*?b"; upper bytes all ones and unused.
    write_pattern(64'd3, 64'h0000_0000_0062_3F2A, '1);
    queue_beat(8'h78, 1'b1, 1'b0, 1'b0);
    queue_beat(LetterB, 1'b0, 1'b1, 1'b0);
    // Text star against a pattern star and against '?'.
    queue_beat(StarCode, 1'b1, 1'b0, 1'b0);
    queue_beat(StarCode, 1'b0, 1'b0, 1'b0);
    queue_beat(LetterB, 1'b0, 1'b1, 1'b0);
    // Byte after the last mark extends the same text.
    queue_beat(LetterB, 1'b0, 1'b1, 1'b0);
    queue_beat(8'h00, 1'b0, 1'b1, 1'b1);
    queue_beat(8'hFF, 1'b1, 1'b1, 1'b0);
    wait_drained();

    // Oversized length saturates; sixteen stars match anything, empty too.
    write_pattern(64'd31, {8{StarCode}}, {8{StarCode}});
    queue_beat(8'h00, 1'b0, 1'b0, 1'b1);
    queue_beat(8'h00, 1'b1, 1'b1, 1'b0);
    wait_drained();

    // New pattern "a*" with junk above the length field; the row from the
    // all-star pattern carries over into the next byte.
    write_pattern(64'hFFFF_FFFF_FFFF_FFE2, 64'h0000_0000_0000_2A61, '0);
    queue_beat(LetterA, 1'b0, 1'b0, 1'b0);
    queue_beat(LetterA, 1'b1, 1'b1, 1'b0);
    queue_beat(StarCode, 1'b1, 1'b1, 1'b0);
    queue_beat(QmarkCode, 1'b1, 1'b0, 1'b0);
    wait_drained();

    for (int ph = 0; ph < RandPhases; ph++) begin
      case ($urandom_range(9))
        0:       len_word = '0;
        1:       len_word = 64'd16;
        2:       len_word = WordW'($urandom_range(17, 31));
        default: len_word = WordW'($urandom_range(1, 8));
      endcase
      len_word[WordW-1:LenW] = (WordW-LenW)'({$urandom, $urandom});
      for (int k = 0; k < 8; k++) begin
        low_word[8*k +: 8]  = pick_pattern_char();
        high_word[8*k +: 8] = pick_pattern_char();
      end
      write_pattern(len_word, low_word, high_word);

      // Idling: none / sender idle / receiver stalling / both lightly.
      case (ph % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      // One phase opens with a long receiver hold-off while beats keep coming.
      if (ph == 5) begin
        send_idle_pct = 0;
        hold_on = 1'b1;
      end

      // Sender pauses halfway until every verdict is back.
      half_mark = beats_queued + PhaseBeats / 2;
      end_mark  = beats_queued + PhaseBeats;
      while (beats_queued < half_mark) queue_random_string();
      wait_drained();
      while (beats_queued < end_mark) queue_random_string();
      wait_drained();
      hold_on = 1'b0;
    end

    repeat (4) @(negedge clk_i);
    if (mismatches == 0 && verdicts_q.size() == 0) begin
      $display("status: pass");
    end else begin
      if (verdicts_q.size() != 0) $display("%0d results never arrived", verdicts_q.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
